// ===== rtl/ntfs_run_list_decoder_defines.svh =====
// Assertion macros shared by the run list decoder RTL.
// Used by the parser and the datapath; no other dependencies.
`ifndef NTFS_RUN_LIST_DECODER_DEFINES_SVH
`define NTFS_RUN_LIST_DECODER_DEFINES_SVH
`ifndef SYNTH
`define RLD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RLD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  `RLD_ASSERT(label, clk, rst, (ante) |=> (cons), msg)
`else
`define RLD_ASSERT(label, clk, rst, prop, msg)
`define RLD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/ntfs_rld_pkg.sv =====
// Types and constants of the NTFS run list decoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ntfs_rld_pkg;

  localparam int WORD_W = 64;
  localparam int SPC_W  = 13;
  localparam int PROD_W = 8 + SPC_W;

  localparam logic [SPC_W-1:0] SPC_RESET = 13'd8;

  typedef enum logic [2:0] {
    STATUS_RUN        = 3'd0,
    STATUS_ZERO_END   = 3'd1,
    STATUS_TRUNCATED  = 3'd2,
    STATUS_STREAM_END = 3'd3,
    STATUS_MALFORMED  = 3'd4
  } status_t;

  typedef enum logic {
    REG_VOLUME_START        = 1'b0,
    REG_SECTORS_PER_CLUSTER = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [7:0] list_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] start_sector;
    logic [WORD_W-1:0] sector_count;
    logic              list_done;
  } out_item_t;

  // One parsed byte on its way from the parser into the arithmetic pipeline.
  typedef struct packed {
    logic       direct;       // result fully known: status below, zero fields
    status_t    status;
    logic       last_of_run;  // final byte of a run
    logic       is_len;       // byte belongs to the cluster count field
    logic [2:0] byte_shift;   // byte index within its field
    logic       run_first;    // first byte of a run: clear the accumulators
    logic       sparse;
    logic       new_list;     // run is the first completed run of its list
    logic       stream_end;
    logic       corr_en;      // negative delta narrower than 64 bits
    logic [2:0] corr_bytes;   // width of the delta field in bytes
    logic [7:0] list_byte;
  } beat_t;

endpackage

`default_nettype wire

// ===== rtl/ntfs_run_list_decoder.sv =====
// NTFS run list decoder, top level: configuration registers, parser, datapath.
// Depends on ntfs_rld_pkg, ntfs_rld_parser and ntfs_rld_datapath.
//
// Usage:
//   Input channel (in_valid, in_stall, in_data): one run list byte per beat,
//   with stream_end marking the last byte of a list. Output channel
//   (out_valid, out_stall, out_data): zero or one result per input beat,
//   in input order. A beat is taken at a clock edge where valid is high
//   and stall is low.
//   Throughput is one byte per cycle while in_stall is low. A result passes
//   through the parser register, which loads at the edge that accepts the
//   byte completing it, then through the byte product, field accumulation,
//   running start sector and result registers.
//   When the receiver stalls, the pipeline keeps taking bytes until its
//   stages are full, including beats that produce no result; then in_stall
//   rises.
//   Configuration (cfg_write, cfg_index, cfg_data) is for the user to write
//   only while no list byte is in flight; the block does not enforce it.
//   Index 0 is the volume start sector, index 1 the sectors per cluster
//   (low 13 bits of cfg_data). Reset (rst, synchronous) empties the
//   pipeline, waits for a header, clears the running cluster number, and
//   sets the volume start to zero and sectors per cluster to eight.
`timescale 1ns / 1ps
`default_nettype none

module ntfs_run_list_decoder #(
  parameter int MAX_FIELD_BYTES = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ntfs_rld_pkg::in_item_t              in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ntfs_rld_pkg::out_item_t             out_data,
  input  logic                                cfg_write,
  input  ntfs_rld_pkg::reg_index_t            cfg_index,
  input  logic [ntfs_rld_pkg::WORD_W-1:0]     cfg_data
);

  logic [ntfs_rld_pkg::WORD_W-1:0] volume_start_sector;
  logic [ntfs_rld_pkg::SPC_W-1:0]  sectors_per_cluster;
  logic                            beat_valid;
  logic                            beat_ready;
  ntfs_rld_pkg::beat_t             beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      volume_start_sector <= '0;
      sectors_per_cluster <= ntfs_rld_pkg::SPC_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ntfs_rld_pkg::REG_VOLUME_START: begin
          volume_start_sector <= cfg_data;
        end
        ntfs_rld_pkg::REG_SECTORS_PER_CLUSTER: begin
          sectors_per_cluster <= cfg_data[ntfs_rld_pkg::SPC_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  ntfs_rld_parser #(
    .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .beat_valid (beat_valid),
    .beat_ready (beat_ready),
    .beat       (beat)
  );

  ntfs_rld_datapath u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .beat_valid          (beat_valid),
    .beat_ready          (beat_ready),
    .beat                (beat),
    .volume_start_sector (volume_start_sector),
    .sectors_per_cluster (sectors_per_cluster),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_data            (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/ntfs_rld_parser.sv =====
// Header and field parser of the decoder: one byte per cycle unless stalled.
// Depends on ntfs_rld_pkg and ntfs_run_list_decoder_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "ntfs_run_list_decoder_defines.svh"

module ntfs_rld_parser #(
  parameter int MAX_FIELD_BYTES = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  ntfs_rld_pkg::in_item_t in_data,
  output logic                   beat_valid,
  input  logic                   beat_ready,
  output ntfs_rld_pkg::beat_t    beat
);

  localparam int PosW = $clog2(2 * MAX_FIELD_BYTES);
  localparam int SzW  = $clog2(MAX_FIELD_BYTES + 1);

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_GATHER = 3'b010,
    PH_SKIP   = 3'b100
  } phase_t;

  phase_t              phase, phase_next;
  logic [SzW-1:0]      length_bytes, length_bytes_next;
  logic [SzW-1:0]      offset_bytes, offset_bytes_next;
  logic [PosW-1:0]     byte_position, byte_position_next;
  logic                fresh, fresh_next;

  logic                load;
  logic                in_acc;
  logic                emit;
  logic [3:0]          hdr_len;
  logic [3:0]          hdr_off;
  logic [PosW:0]       total;
  logic [PosW:0]       pos_inc;
  logic [PosW-1:0]     off_pos;
  logic                is_len;
  logic                run_done;
  ntfs_rld_pkg::beat_t beat_next;

  assign in_stall = beat_valid && !beat_ready;
  assign load     = !in_stall;
  assign in_acc   = in_valid && load;

  assign hdr_len  = in_data.list_byte[3:0];
  assign hdr_off  = in_data.list_byte[7:4];
  assign total    = (PosW + 1)'(length_bytes) + (PosW + 1)'(offset_bytes);
  assign pos_inc  = {1'b0, byte_position} + (PosW + 1)'(1);
  assign off_pos  = byte_position - PosW'(length_bytes);
  assign is_len   = byte_position < PosW'(length_bytes);
  assign run_done = pos_inc >= total;

  always_comb begin
    phase_next         = phase;
    length_bytes_next  = length_bytes;
    offset_bytes_next  = offset_bytes;
    byte_position_next = byte_position;
    fresh_next         = fresh;
    emit               = 1'b0;

    beat_next.direct      = 1'b0;
    beat_next.status      = ntfs_rld_pkg::STATUS_RUN;
    beat_next.last_of_run = run_done;
    beat_next.is_len      = is_len;
    beat_next.byte_shift  = is_len ? 3'(byte_position) : 3'(off_pos);
    beat_next.run_first   = (byte_position == '0);
    beat_next.sparse      = (offset_bytes == '0);
    beat_next.new_list    = fresh;
    beat_next.stream_end  = in_data.stream_end;
    // Only the top byte of a delta narrower than 64 bits needs sign extension.
    beat_next.corr_en     = run_done && (offset_bytes != '0) && (4'(offset_bytes) < 4'd8)
                            && in_data.list_byte[7];
    beat_next.corr_bytes  = 3'(offset_bytes);
    beat_next.list_byte   = in_data.list_byte;

    if (in_acc) begin
      unique case (phase)
        PH_HEADER: begin
          if (in_data.list_byte == 8'h00) begin
            emit             = 1'b1;
            beat_next.direct = 1'b1;
            beat_next.status = ntfs_rld_pkg::STATUS_ZERO_END;
            fresh_next       = 1'b1;
            phase_next       = in_data.stream_end ? PH_HEADER : PH_SKIP;
          end else if (hdr_len > 4'(MAX_FIELD_BYTES) || hdr_off > 4'(MAX_FIELD_BYTES)) begin
            emit             = 1'b1;
            beat_next.direct = 1'b1;
            beat_next.status = ntfs_rld_pkg::STATUS_MALFORMED;
            fresh_next       = 1'b1;
            phase_next       = in_data.stream_end ? PH_HEADER : PH_SKIP;
          end else if (in_data.stream_end) begin
            emit             = 1'b1;
            beat_next.direct = 1'b1;
            beat_next.status = ntfs_rld_pkg::STATUS_TRUNCATED;
            fresh_next       = 1'b1;
          end else begin
            length_bytes_next  = SzW'(hdr_len);
            offset_bytes_next  = SzW'(hdr_off);
            byte_position_next = '0;
            phase_next         = PH_GATHER;
          end
        end
        PH_GATHER: begin
          emit = 1'b1;
          if (!run_done) begin
            byte_position_next = PosW'(pos_inc);
            if (in_data.stream_end) begin
              beat_next.direct   = 1'b1;
              beat_next.status   = ntfs_rld_pkg::STATUS_TRUNCATED;
              byte_position_next = '0;
              fresh_next         = 1'b1;
              phase_next         = PH_HEADER;
            end
          end else begin
            byte_position_next = '0;
            fresh_next         = in_data.stream_end;
            phase_next         = PH_HEADER;
          end
        end
        PH_SKIP: begin
          if (in_data.stream_end) begin
            fresh_next = 1'b1;
            phase_next = PH_HEADER;
          end
        end
        default: begin
          phase_next = PH_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      length_bytes  <= '0;
      offset_bytes  <= '0;
      byte_position <= '0;
      fresh         <= 1'b1;
      beat_valid    <= 1'b0;
    end else begin
      phase         <= phase_next;
      length_bytes  <= length_bytes_next;
      offset_bytes  <= offset_bytes_next;
      byte_position <= byte_position_next;
      fresh         <= fresh_next;
      if (load) begin
        beat_valid <= in_acc && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      beat <= beat_next;
    end
  end

  `RLD_ASSERT(a_pos_in_run, clk, rst, (phase == PH_GATHER) |-> (pos_inc <= total), "byte position past end of run")
  `RLD_ASSERT_NEXT(a_end_in_run, clk, rst, in_acc && phase == PH_GATHER && in_data.stream_end, phase == PH_HEADER && fresh && beat_valid, "stream end inside a run did not close the list")
  `RLD_ASSERT_NEXT(a_zero_skip, clk, rst, in_acc && phase == PH_HEADER && in_data.list_byte == 8'h00 && !in_data.stream_end, phase == PH_SKIP && beat_valid && beat.direct, "zero header did not start a skip")

endmodule

`default_nettype wire

// ===== rtl/ntfs_rld_datapath.sv =====
// Arithmetic pipeline of the run list decoder: byte products, field
// accumulation, running start sector and the result register.
// Depends on ntfs_rld_pkg and ntfs_run_list_decoder_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "ntfs_run_list_decoder_defines.svh"

module ntfs_rld_datapath (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    beat_valid,
  output logic                                    beat_ready,
  input  ntfs_rld_pkg::beat_t                     beat,
  input  logic [ntfs_rld_pkg::WORD_W-1:0]         volume_start_sector,
  input  logic [ntfs_rld_pkg::SPC_W-1:0]          sectors_per_cluster,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output ntfs_rld_pkg::out_item_t                 out_data
);

  localparam int W = ntfs_rld_pkg::WORD_W;

  // Stage 2: byte times sectors per cluster, and the sign correction.
  logic                             v2;
  ntfs_rld_pkg::beat_t              s2_beat;
  logic [ntfs_rld_pkg::PROD_W-1:0]  s2_prod;
  logic [W-1:0]                     s2_corr;
  // Stage 3: count and delta accumulated in sectors.
  logic                             v3;
  ntfs_rld_pkg::beat_t              s3_beat;
  logic [W-1:0]                     s3_count;
  logic [W-1:0]                     s3_delta;
  logic [W-1:0]                     count_acc;
  logic [W-1:0]                     delta_acc;
  // Stage 4: running cluster number, kept scaled to sectors.
  logic                             v4;
  ntfs_rld_pkg::beat_t              s4_beat;
  logic [W-1:0]                     s4_count;
  logic [W-1:0]                     s4_rsum;
  logic [W-1:0]                     running_sector;

  logic                             r2, r3, r4, r5;
  logic [ntfs_rld_pkg::PROD_W-1:0]  prod_c;
  logic [W-1:0]                     corr_c;
  logic [W-1:0]                     contrib;
  logic [W-1:0]                     count_new;
  logic [W-1:0]                     delta_new;
  logic [W-1:0]                     rs_base;
  logic [W-1:0]                     rs_sum;
  logic                             is_run;
  logic                             emit4;
  ntfs_rld_pkg::out_item_t          out_next;

  assign r5         = !out_valid || !out_stall;
  assign r4         = !v4 || r5;
  assign r3         = !v3 || r4;
  assign r2         = !v2 || r3;
  assign beat_ready = r2;

  assign prod_c = ntfs_rld_pkg::PROD_W'(beat.list_byte)
                * ntfs_rld_pkg::PROD_W'(sectors_per_cluster);
  assign corr_c = beat.corr_en ? (W'(sectors_per_cluster) << {beat.corr_bytes, 3'b000})
                               : '0;

  assign contrib   = W'(s2_prod) << {s2_beat.byte_shift, 3'b000};
  assign count_new = (s2_beat.run_first ? '0 : count_acc) + (s2_beat.is_len ? contrib : '0);
  assign delta_new = (s2_beat.run_first ? '0 : delta_acc) + (s2_beat.is_len ? '0 : contrib)
                   - s2_corr;

  assign rs_base = s3_beat.new_list ? '0 : running_sector;
  assign rs_sum  = rs_base + s3_delta;

  assign is_run = !s4_beat.sparse && (s4_count != '0);
  assign emit4  = s4_beat.direct || is_run || s4_beat.stream_end;

  always_comb begin
    out_next.status       = ntfs_rld_pkg::STATUS_STREAM_END;
    out_next.start_sector = '0;
    out_next.sector_count = '0;
    out_next.list_done    = 1'b1;
    if (s4_beat.direct) begin
      out_next.status = s4_beat.status;
    end else if (is_run) begin
      out_next.status       = ntfs_rld_pkg::STATUS_RUN;
      out_next.start_sector = volume_start_sector + s4_rsum;
      out_next.sector_count = s4_count;
      out_next.list_done    = s4_beat.stream_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2             <= 1'b0;
      v3             <= 1'b0;
      v4             <= 1'b0;
      out_valid      <= 1'b0;
      running_sector <= '0;
    end else begin
      if (r2) begin
        v2 <= beat_valid;
      end
      // Middle bytes of a run end in the accumulators and go no further.
      if (r3) begin
        v3 <= v2 && (s2_beat.direct || s2_beat.last_of_run);
      end
      if (r4) begin
        v4 <= v3;
      end
      if (r4 && v3 && !s3_beat.direct) begin
        running_sector <= rs_sum;
      end
      if (r5) begin
        out_valid <= v4 && emit4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r2 && beat_valid) begin
      s2_beat <= beat;
      s2_prod <= prod_c;
      s2_corr <= corr_c;
    end
    if (r3 && v2) begin
      s3_beat  <= s2_beat;
      s3_count <= count_new;
      s3_delta <= delta_new;
      if (!s2_beat.direct) begin
        count_acc <= count_new;
        delta_acc <= delta_new;
      end
    end
    if (r4 && v3) begin
      s4_beat  <= s3_beat;
      s4_count <= s3_count;
      s4_rsum  <= rs_sum;
    end
    if (r5 && v4) begin
      out_data <= out_next;
    end
  end

  `RLD_ASSERT(a_end_done, clk, rst, out_valid && out_data.status != ntfs_rld_pkg::STATUS_RUN |-> out_data.list_done, "non-run result without list end")
  `RLD_ASSERT(a_run_count, clk, rst, out_valid && out_data.status == ntfs_rld_pkg::STATUS_RUN |-> out_data.sector_count != '0, "run result with zero sectors")
  `RLD_ASSERT_NEXT(a_direct_out, clk, rst, v4 && r5 && s4_beat.direct, out_valid && out_data.list_done && out_data.sector_count == '0, "list end beat lost")

endmodule

`default_nettype wire

// ===== sim/tb_ntfs_run_list_decoder.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ntfs_run_list_decoder: feeds run list bytes, predicts each
// result with a behavioral run list decoder and compares it with the block's output.
// Depends on ntfs_rld_pkg and the RTL of the block.

module tb_ntfs_run_list_decoder;

  localparam int MAX_FIELD_BYTES = 8;
  localparam int DRAIN_CYCLES = 12;
  localparam int QUIET_LIMIT = 3000;
  localparam int MAX_REPORTS = 10;

  typedef enum logic [1:0] {WAIT_HEADER, GATHER_FIELDS, SKIP_TO_END} parse_phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  ntfs_rld_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ntfs_rld_pkg::out_item_t out_data;
  logic cfg_write = 1'b0;
  ntfs_rld_pkg::reg_index_t cfg_index = ntfs_rld_pkg::REG_VOLUME_START;
  logic [ntfs_rld_pkg::WORD_W-1:0] cfg_data = '0;

  // Predicted decoder state and its copy of the registers.
  logic [ntfs_rld_pkg::WORD_W-1:0] vol_start;
  logic [ntfs_rld_pkg::SPC_W-1:0] clus_sectors;
  parse_phase_t parse_phase;
  logic [3:0] len_bytes;
  logic [3:0] off_bytes;
  logic [3:0] field_pos;
  logic [ntfs_rld_pkg::WORD_W-1:0] count_acc;
  logic [ntfs_rld_pkg::WORD_W-1:0] delta_acc;
  logic [ntfs_rld_pkg::WORD_W-1:0] cur_lcn;

  ntfs_rld_pkg::out_item_t pending_results[$];
  int mismatches = 0;
  int bytes_sent = 0;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int hold_request = 0;

  ntfs_run_list_decoder #(.MAX_FIELD_BYTES(MAX_FIELD_BYTES)) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void restart_list();
    parse_phase = WAIT_HEADER;
    len_bytes = '0;
    off_bytes = '0;
    field_pos = '0;
    count_acc = '0;
    delta_acc = '0;
    cur_lcn = '0;
  endfunction

  // Advances the decoder by one list byte; returns 1 when the byte yields a result.
  function automatic bit decode_run_byte(input ntfs_rld_pkg::in_item_t beat,
                                         output ntfs_rld_pkg::out_item_t res);
    bit produced;
    logic [7:0] b;
    logic [3:0] lsz;
    logic [3:0] osz;
    logic [4:0] total;
    logic [ntfs_rld_pkg::WORD_W-1:0] spc64;
    logic [ntfs_rld_pkg::WORD_W-1:0] sectors;
    logic [ntfs_rld_pkg::WORD_W-1:0] first;
    logic [ntfs_rld_pkg::WORD_W-1:0] delta;
    produced = 1'b0;
    res = '0;
    res.status = ntfs_rld_pkg::STATUS_RUN;
    b = beat.list_byte;
    spc64 = {{(ntfs_rld_pkg::WORD_W-ntfs_rld_pkg::SPC_W){1'b0}}, clus_sectors};
    case (parse_phase)
      SKIP_TO_END: begin
        if (beat.stream_end) restart_list();
      end
      WAIT_HEADER: begin
        lsz = b[3:0];
        osz = b[7:4];
        if (b == 8'h00 || lsz > 4'(MAX_FIELD_BYTES) || osz > 4'(MAX_FIELD_BYTES)) begin
          produced = 1'b1;
          res.status = (b == 8'h00) ? ntfs_rld_pkg::STATUS_ZERO_END
                                    : ntfs_rld_pkg::STATUS_MALFORMED;
          res.list_done = 1'b1;
          if (beat.stream_end) restart_list();
          else parse_phase = SKIP_TO_END;
        end else if (beat.stream_end) begin
          restart_list();
          produced = 1'b1;
          res.status = ntfs_rld_pkg::STATUS_TRUNCATED;
          res.list_done = 1'b1;
        end else begin
          len_bytes = lsz;
          off_bytes = osz;
          field_pos = '0;
          count_acc = '0;
          delta_acc = '0;
          parse_phase = GATHER_FIELDS;
        end
      end
      default: begin
        total = 5'(len_bytes) + 5'(off_bytes);
        if (field_pos < len_bytes) count_acc |= {56'd0, b} << (8 * field_pos);
        else delta_acc |= {56'd0, b} << (8 * (field_pos - len_bytes));
        if (field_pos + 5'd1 < total) begin
          field_pos = field_pos + 4'd1;
          if (beat.stream_end) begin
            restart_list();
            produced = 1'b1;
            res.status = ntfs_rld_pkg::STATUS_TRUNCATED;
            res.list_done = 1'b1;
          end
        end else begin
          sectors = count_acc * spc64;
          first = '0;
          if (off_bytes != 4'd0) begin
            delta = delta_acc;
            // Offset fields narrower than eight bytes are signed.
            if (off_bytes < 4'd8 && delta[8 * off_bytes - 1]) delta = delta | (~64'd0 << (8 * off_bytes));
            cur_lcn = cur_lcn + delta;
            first = vol_start + cur_lcn * spc64;
          end
          parse_phase = WAIT_HEADER;
          field_pos = '0;
          if (off_bytes != 4'd0 && sectors != '0) begin
            produced = 1'b1;
            res.start_sector = first;
            res.sector_count = sectors;
            res.list_done = beat.stream_end;
            if (beat.stream_end) restart_list();
          end else if (beat.stream_end) begin
            restart_list();
            produced = 1'b1;
            res.status = ntfs_rld_pkg::STATUS_STREAM_END;
            res.list_done = 1'b1;
          end
        end
      end
    endcase
    return produced;
  endfunction

  // Offers one byte, holds it until the block takes it, then predicts its result.
  task automatic send_byte(input logic [7:0] b, input bit last);
    ntfs_rld_pkg::out_item_t res;
    while (tx_idle_en && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{list_byte: b, stream_end: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (decode_run_byte('{list_byte: b, stream_end: last}, res))
      pending_results = {pending_results, res};
    bytes_sent++;
  endtask

  task automatic write_reg(input ntfs_rld_pkg::reg_index_t idx,
                           input logic [ntfs_rld_pkg::WORD_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (idx == ntfs_rld_pkg::REG_VOLUME_START) vol_start = value;
    else clus_sectors = value[ntfs_rld_pkg::SPC_W-1:0];
  endtask

  // Lets every expected result come out and the pipeline run empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_size(input bit is_offset);
    int r;
    r = $urandom_range(99);
    if (is_offset && r < 10) return 0;
    if (r < 80) return $urandom_range(3, 1);
    return $urandom_range(8, is_offset ? 4 : 0);
  endfunction

  // One run: header, count bytes, offset bytes. A cut position ends the list early.
  task automatic send_run(input int lsz, input int osz, input int cut_at, input bit last_run);
    int n;
    bit zero_count;
    logic [7:0] b;
    n = lsz + osz;
    zero_count = ($urandom_range(15) == 0);
    send_byte({osz[3:0], lsz[3:0]}, cut_at == 0);
    if (cut_at == 0) return;
    for (int i = 1; i <= n; i++) begin
      b = 8'($urandom_range(255));
      if (i <= lsz && zero_count) b = 8'h00;
      send_byte(b, (i == cut_at) || (i == n && last_run));
      if (i == cut_at) return;
    end
  endtask

  task automatic send_tail_junk();
    int n;
    n = $urandom_range(4, 0);
    for (int i = 0; i < n; i++) send_byte(8'($urandom_range(255)), 1'b0);
    send_byte(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_list();
    int runs;
    int ending;
    int lsz;
    int osz;
    logic [7:0] bad;
    runs = $urandom_range(6, 1);
    ending = $urandom_range(99);
    for (int k = 1; k <= runs; k++) begin
      lsz = pick_size(1'b0);
      osz = pick_size(1'b1);
      if (lsz == 0 && osz == 0) lsz = 1;
      if (k == runs && ending < 50) send_run(lsz, osz, -1, 1'b1);
      else if (k == runs && ending < 65) send_run(lsz, osz, $urandom_range(lsz + osz - 1, 0), 1'b0);
      else send_run(lsz, osz, -1, 1'b0);
    end
    if (ending >= 65 && ending < 85) begin
      if ($urandom_range(1)) send_byte(8'h00, 1'b1);
      else begin
        send_byte(8'h00, 1'b0);
        send_tail_junk();
      end
    end else if (ending >= 85) begin
      bad = 8'($urandom_range(255));
      if ($urandom_range(1)) bad[3:0] = 4'($urandom_range(15, 9));
      else bad[7:4] = 4'($urandom_range(15, 9));
      if ($urandom_range(1)) send_byte(bad, 1'b1);
      else begin
        send_byte(bad, 1'b0);
        send_tail_junk();
      end
    end
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(12, 1);
    for (int i = 1; i < n; i++) send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
    send_byte(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic run_random_lists(input int n_bytes);
    int target;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      if ($urandom_range(9) == 0) send_noise();
      else send_list();
    end
    wait_idle();
  endtask

  task automatic test_directed_cases();
    send_byte(8'h00, 1'b1);
    // A zero header in mid stream makes the rest of the list ignored.
    send_byte(8'h00, 1'b0);
    send_byte(8'hAB, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h19, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h91, 1'b1);
    send_byte(8'h11, 1'b1);
    send_byte(8'h21, 1'b0);
    send_byte(8'h05, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h04, 1'b1);
    send_byte(8'h11, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h10, 1'b0);
    // Negative delta takes the running cluster below zero, then back up.
    send_byte(8'h11, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b1);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    write_reg(ntfs_rld_pkg::REG_VOLUME_START, ~64'd0);
    write_reg(ntfs_rld_pkg::REG_SECTORS_PER_CLUSTER, 64'd4096);
    run_random_lists(350);
  endtask

  task automatic test_single_sector_clusters();
    write_reg(ntfs_rld_pkg::REG_VOLUME_START, {$urandom, $urandom});
    write_reg(ntfs_rld_pkg::REG_SECTORS_PER_CLUSTER, 64'd1);
    run_random_lists(350);
  endtask

  task automatic test_zero_sector_clusters();
    write_reg(ntfs_rld_pkg::REG_SECTORS_PER_CLUSTER, 64'd0);
    run_random_lists(80);
  endtask

  task automatic test_unbroken_flow();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    write_reg(ntfs_rld_pkg::REG_VOLUME_START, 64'd0);
    // Bits above the register width must be dropped by the block.
    write_reg(ntfs_rld_pkg::REG_SECTORS_PER_CLUSTER,
              {$urandom, 19'h7FFFF, 13'($urandom_range(4096, 1))});
    run_random_lists(400);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_output_backpressure();
    write_reg(ntfs_rld_pkg::REG_VOLUME_START, {$urandom, $urandom});
    write_reg(ntfs_rld_pkg::REG_SECTORS_PER_CLUSTER, 64'd8);
    tx_idle_en = 1'b0;
    hold_request = 400;
    run_random_lists(150);
    tx_idle_en = 1'b1;
    run_random_lists(300);
  endtask

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= rx_idle_en && ($urandom_range(99) < 25);
      end
    end
  end

  initial begin : result_checker
    ntfs_rld_pkg::out_item_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: status %0d start %h count %h done %b",
                     out_data.status, out_data.start_sector, out_data.sector_count,
                     out_data.list_done);
        end else begin
          want = pending_results.pop_front();
          if (out_data.status !== want.status || out_data.start_sector !== want.start_sector ||
              out_data.sector_count !== want.sector_count ||
              out_data.list_done !== want.list_done) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch: expected status %0d start %h count %h done %b, got %0d %h %h %b",
                       want.status, want.start_sector, want.sector_count, want.list_done,
                       out_data.status, out_data.start_sector, out_data.sector_count,
                       out_data.list_done);
          end
        end
      end
    end
  end

  // Ends the run when no beat moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    vol_start = '0;
    clus_sectors = ntfs_rld_pkg::SPC_RESET;
    restart_list();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_config_extremes();
    test_single_sector_clusters();
    test_zero_sector_clusters();
    test_unbroken_flow();
    test_output_backpressure();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
